// File: rtl/alb_pkg.sv
// Package for the array search engine: opcode and status codes, field widths
// and the default table depth. Used by the interfaces, the top, the controller and the testbench.
`default_nettype none
package alb_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 7;
  localparam int FILL_W    = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LINEAR = 2'd2,
    OP_BINARY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2,
    ST_HIT  = 2'd3
  } status_t;

endpackage
`default_nettype wire

// File: rtl/alb_if.sv
// Valid/ready channel interfaces for the command word and the result word.
// Depends on alb_pkg for the field types.
`default_nettype none
interface alb_in_if;
  logic                             valid;
  logic                             ready;
  alb_pkg::opcode_t                 opcode;
  logic signed [alb_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface alb_out_if;
  logic                          valid;
  logic                          ready;
  alb_pkg::status_t              status;
  logic [alb_pkg::POS_W-1:0]     position;
  logic [alb_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, output status, output position, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input position, input fill_count,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/array_linear_binary_search_top.sv
// Channel      | Dir | Payload                          | Word accepted when
// in_ch        | in  | opcode, value                    | in_ch.valid && in_ch.ready
// out_ch       | out | status, position, fill_count     | out_ch.valid && out_ch.ready
//
// Clear and append pass from acceptance through the S_RESP state into the output register.
// A linear search reads the N stored elements in order up to the first hit, one table
// RAM read per cycle; a binary search halves its search window with each probe.
// Reset is synchronous and empties the table; the RAM itself is not cleared.
// The result word waits in an output register, so a stalled sink holds at
// most one finished word while the next command is taken and worked on.
`default_nettype none
module array_linear_binary_search_top #(
  parameter int DEPTH = alb_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  alb_in_if.sink    in_ch,
  alb_out_if.source out_ch
);
  import alb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  alb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  alb_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/alb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module alb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/alb_ctrl.sv
// Command sequencer of the search engine: element count, linear and binary
// probe loops over the table RAM, and the result register. Uses alb_pkg, alb_if.
`default_nettype none
module alb_ctrl #(
  parameter int DEPTH = alb_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  alb_in_if.sink                              in_ch,
  alb_out_if.source                           out_ch,
  output logic                                ram_we,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr,
  output logic [alb_pkg::VAL_W-1:0]           ram_wdata,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr,
  input  wire logic [alb_pkg::VAL_W-1:0]      ram_rdata
);
  import alb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            lo_r, lo_nxt;
  logic [CW-1:0]            hip_r, hip_nxt;
  logic                     bin_r, bin_nxt;
  logic signed [VAL_W-1:0]  key_r, key_nxt;
  status_t                  res_st_r, res_st_nxt;
  logic [CW-1:0]            res_pos_r, res_pos_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_st_r, out_st_nxt;
  logic [POS_W-1:0]         out_pos_r, out_pos_nxt;
  logic [FILL_W-1:0]        out_fill_r, out_fill_nxt;

  logic                     accept;
  logic                     hit;
  logic                     less;
  logic [CW-1:0]            lin_next;
  logic [CW-1:0]            bin_lo;
  logic [CW-1:0]            bin_hip;
  logic [CW:0]              mid_sum;
  logic [CW:0]              first_sum;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.position   = out_pos_r;
  assign out_ch.fill_count = out_fill_r;

  assign hit       = (ram_rdata == key_r);
  assign less      = ($signed(ram_rdata) < key_r);
  assign lin_next  = idx_r + CW'(1);
  assign bin_lo    = less ? idx_r + CW'(1) : lo_r;
  assign bin_hip   = less ? hip_r : idx_r;
  assign mid_sum   = {1'b0, bin_lo} + {1'b0, bin_hip} - (CW + 1)'(1);
  assign first_sum = {1'b0, count_r} - (CW + 1)'(1);

  assign ram_we    = accept && (in_ch.opcode == OP_APPEND) && (count_r < FULL_CNT);
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = in_ch.value;
  assign ram_raddr = idx_nxt[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hip_nxt       = hip_r;
    bin_nxt       = bin_r;
    key_nxt       = key_r;
    res_st_nxt    = res_st_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_pos_nxt   = out_pos_r;
    out_fill_nxt  = out_fill_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt     = in_ch.value;
          res_pos_nxt = '0;
          res_st_nxt  = ST_DONE;
          state_nxt   = S_RESP;
          unique case (in_ch.opcode) inside
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < FULL_CNT) begin
                count_nxt = count_r + CW'(1);
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            OP_LINEAR, OP_BINARY: begin
              bin_nxt = (in_ch.opcode == OP_BINARY);
              lo_nxt  = '0;
              hip_nxt = count_r;
              if (count_r == '0) begin
                res_st_nxt = ST_MISS;
              end else begin
                state_nxt = S_SCAN;
                idx_nxt   = (in_ch.opcode == OP_BINARY) ? first_sum[CW:1] : '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_st_nxt  = ST_HIT;
          res_pos_nxt = idx_r;
          state_nxt   = S_RESP;
        end else if (!bin_r) begin
          if (lin_next == count_r) begin
            res_st_nxt = ST_MISS;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt = lin_next;
          end
        end else begin
          lo_nxt  = bin_lo;
          hip_nxt = bin_hip;
          if (bin_lo < bin_hip) begin
            idx_nxt = mid_sum[CW:1];
          end else begin
            res_st_nxt = ST_MISS;
            state_nxt  = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_pos_nxt   = POS_W'(res_pos_r);
          out_fill_nxt  = FILL_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    lo_r       <= lo_nxt;
    hip_r      <= hip_nxt;
    bin_r      <= bin_nxt;
    key_r      <= key_nxt;
    res_st_r   <= res_st_nxt;
    res_pos_r  <= res_pos_nxt;
    out_st_r   <= out_st_nxt;
    out_pos_r  <= out_pos_nxt;
    out_fill_r <= out_fill_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("element count above table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < count_r) else $error("probe beyond element count");

  a_bin_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && bin_r) |-> (lo_r <= idx_r && idx_r < hip_r))
    else $error("binary probe outside search window");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE) else $error("table write outside idle");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded into free output register");

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for the array search engine: directed and random command words,
// with every result word checked against a model of the table and its searches.
// Depends on alb_pkg, the channel interfaces and array_linear_binary_search_top.
module tb;
  import alb_pkg::*;

  localparam int TABLE_DEPTH    = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [VAL_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } answer_t;

  class search_scoreboard;
    logic signed [VAL_W-1:0] words [TABLE_DEPTH];
    int                      count;
    answer_t                 pending_answers [$];
    int                      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function answer_t predict_answer(opcode_t op, logic signed [VAL_W-1:0] key);
      answer_t ans;
      int      lo;
      int      hi;
      int      mid;
      int      idx;
      bit      hit;
      ans.status   = ST_DONE;
      ans.position = '0;
      hit          = 1'b0;
      case (op)
        OP_CLEAR: begin
          count = 0;
        end
        OP_APPEND: begin
          if (count < TABLE_DEPTH) begin
            words[count] = key;
            count++;
          end else begin
            ans.status = ST_FULL;
          end
        end
        OP_LINEAR: begin
          for (idx = 0; idx < count && !hit; idx++) begin
            if (words[idx] == key) begin
              hit          = 1'b1;
              ans.position = idx[POS_W-1:0];
            end
          end
          ans.status = hit ? ST_HIT : ST_MISS;
        end
        default: begin
          lo = 0;
          hi = count - 1;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (words[mid] == key) begin
              hit          = 1'b1;
              ans.position = mid[POS_W-1:0];
            end else if (words[mid] < key) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          ans.status = hit ? ST_HIT : ST_MISS;
        end
      endcase
      ans.fill_count = count[FILL_W-1:0];
      return ans;
    endfunction

    function void note_command(opcode_t op, logic signed [VAL_W-1:0] key);
      pending_answers.push_back(predict_answer(op, key));
    endfunction

    function void check_result(status_t status, logic [POS_W-1:0] position,
                               logic [FILL_W-1:0] fill_count);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result word: status %0d position %0d fill_count %0d",
                 $time, status, position, fill_count);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position, position);
        errors++;
      end
      if (fill_count !== want.fill_count) begin
        $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                 fill_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  alb_in_if  in_ch ();
  alb_out_if out_ch ();

  array_linear_binary_search_top #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  search_scoreboard        sb = new();
  int                      tx_idle_pct;
  int                      rx_idle_pct;
  bit                      hold_req;
  int                      items_sent;
  int                      quiet_cycles;
  logic signed [VAL_W-1:0] table_shadow [$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.status, out_ch.position, out_ch.fill_count);
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_command(in_ch.opcode, in_ch.value);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_cmd(opcode_t op, logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.opcode = op;
    in_ch.value  = val;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    case (op)
      OP_CLEAR: begin
        table_shadow.delete();
      end
      OP_APPEND: begin
        if (table_shadow.size() < TABLE_DEPTH) table_shadow.push_back(val);
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int near_zero;
    near_zero = int'($urandom_range(40)) - 20;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      1, 2, 3: return near_zero;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_key();
    int idx;
    if (table_shadow.size() == 0 || $urandom_range(2) == 0) return pick_value();
    idx = $urandom_range(table_shadow.size() - 1);
    case ($urandom_range(3))
      0:       return table_shadow[idx] + 1;
      1:       return table_shadow[idx] - 1;
      default: return table_shadow[idx];
    endcase
  endfunction

  task automatic run_table_set(bit sorted, bit fill_up);
    int vals [$];
    int n_items;
    if (sorted || $urandom_range(1)) send_cmd(OP_CLEAR, pick_value());
    if (fill_up) begin
      n_items = TABLE_DEPTH + $urandom_range(1, 4);
    end else if ($urandom_range(29) == 0) begin
      n_items = $urandom_range(32, TABLE_DEPTH);
    end else begin
      n_items = $urandom_range(0, 12);
    end
    repeat (n_items) vals.push_back(pick_value());
    if (sorted) vals.sort();
    foreach (vals[i]) send_cmd(OP_APPEND, vals[i]);
    repeat ($urandom_range(2, 8)) begin
      send_cmd($urandom_range(1) ? OP_LINEAR : OP_BINARY, pick_key());
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      send_cmd(opcode_t'($urandom_range(3)), $urandom_range(1) ? pick_value() : pick_key());
    end
  endtask

  initial begin
    int base;
    int pick;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.value  = '0;
    tx_idle_pct  = 20;
    rx_idle_pct  = 60;
    hold_req     = 1'b0;
    items_sent   = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Searches of the empty table, then a sorted table holding the extremes.
    send_cmd(OP_LINEAR, MOST_POS);
    send_cmd(OP_BINARY, MOST_NEG);
    send_cmd(OP_APPEND, MOST_NEG);
    send_cmd(OP_APPEND, -1);
    send_cmd(OP_APPEND, 0);
    send_cmd(OP_APPEND, 1);
    send_cmd(OP_APPEND, MOST_POS);
    send_cmd(OP_LINEAR, MOST_POS);
    send_cmd(OP_BINARY, MOST_NEG);
    send_cmd(OP_BINARY, 0);
    send_cmd(OP_BINARY, 2);
    send_cmd(OP_LINEAR, 5);
    // A duplicate must be found at its first index, and a trailing small word
    // leaves the table unsorted for the binary search.
    send_cmd(OP_APPEND, 1);
    send_cmd(OP_LINEAR, 1);
    send_cmd(OP_APPEND, -5);
    send_cmd(OP_BINARY, -5);
    send_cmd(OP_LINEAR, -5);
    // After a clear the old words stay in memory but must not be found.
    send_cmd(OP_CLEAR, -1);
    send_cmd(OP_LINEAR, 0);
    send_cmd(OP_BINARY, MOST_POS);
    send_cmd(OP_APPEND, MOST_POS);
    send_cmd(OP_BINARY, MOST_POS);

    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 20 : 0;
      if (ph == 2) hold_req = 1'b1;
      if (ph != 1) run_table_set(1'b1, 1'b1);
      while (items_sent < base + (ph + 1) * RANDOM_ITEMS / 3) begin
        pick = $urandom_range(19);
        if (pick < 12) begin
          run_table_set(1'b1, 1'b0);
        end else if (pick < 17) begin
          run_table_set(1'b0, 1'b0);
        end else begin
          run_noise();
        end
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/alb_pkg.sv
rtl/alb_if.sv
rtl/alb_ram.sv
rtl/alb_ctrl.sv
rtl/array_linear_binary_search_top.sv
sim/tb.sv
